@@ rtl/core/utf8_display_text_validator_top_macros.svh @@
// assertion macros for the utf8 display text validator
`ifndef UTF8_DISPLAY_TEXT_VALIDATOR_TOP_MACROS_SVH
`define UTF8_DISPLAY_TEXT_VALIDATOR_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, disabled during reset
`define UTF8V_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("utf8v assertion failed");

// next-cycle implication, disabled during reset
`define UTF8V_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("utf8v assertion failed");

`else

`define UTF8V_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define UTF8V_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/core/utf8v_pkg.sv @@
// shared types and constants for the utf8 display text validator
package utf8v_pkg;

    // largest byte limit the design applies
    localparam int MAX_TEXT_BYTES = 4095;
    localparam int COUNT_W        = 12;
    localparam logic [COUNT_W-1:0] LIMIT_RESET = 12'd256;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_TOO_LONG  = 3'd1,
        ERR_BAD_LEAD  = 3'd2,
        ERR_BAD_CONT  = 3'd3,
        ERR_TRUNCATED = 3'd4,
        ERR_RANGE     = 3'd5,
        ERR_FORBIDDEN = 3'd6
    } err_kind_t;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       has_byte;
        logic       text_end;
    } in_item_t;

    typedef struct packed {
        logic      text_ok;
        err_kind_t error_kind;
    } out_item_t;

    // running decode state of the current text
    typedef struct packed {
        logic [1:0]         expected;
        logic [20:0]        cp;
        logic [1:0]         cls;
        logic [COUNT_W-1:0] count;
        err_kind_t          err;
    } dec_state_t;

endpackage

@@ rtl/core/utf8v_decode.sv @@
// combinational next-state and verdict logic for one byte transaction
module utf8v_decode
(
    input  utf8v_pkg::dec_state_t          cur,
    input  utf8v_pkg::in_item_t            item,
    input  logic [utf8v_pkg::COUNT_W-1:0]  limit,
    output utf8v_pkg::dec_state_t          nxt,
    output utf8v_pkg::out_item_t           result
);

    // control characters and bidi / separator format characters
    function automatic logic is_forbidden(input logic [20:0] cp);
        begin
            is_forbidden = (cp < 21'h20)
                || (cp >= 21'h7f && cp <= 21'h9f)
                || (cp == 21'h061c)
                || (cp >= 21'h200e && cp <= 21'h200f)
                || (cp >= 21'h2028 && cp <= 21'h202e)
                || (cp >= 21'h2066 && cp <= 21'h2069);
        end
    endfunction

    // range, overlong, surrogate and forbidden-character check on a finished code point
    function automatic utf8v_pkg::err_kind_t check_cp(input logic [20:0] cp,
                                                      input logic [1:0] cls);
        logic [20:0] minimum;
        begin
            case (cls)
                2'd1:    minimum = 21'h80;
                2'd2:    minimum = 21'h800;
                default: minimum = 21'h10000;
            endcase
            if (cp < minimum || cp > 21'h10ffff || (cp >= 21'hd800 && cp <= 21'hdfff))
                check_cp = utf8v_pkg::ERR_RANGE;
            else if (is_forbidden(cp))
                check_cp = utf8v_pkg::ERR_FORBIDDEN;
            else
                check_cp = utf8v_pkg::ERR_NONE;
        end
    endfunction

    logic [7:0]            b;
    logic [20:0]           cp_shift;
    utf8v_pkg::dec_state_t upd;
    utf8v_pkg::err_kind_t  fin_err;

    assign b        = item.byte_value;
    assign cp_shift = {cur.cp[14:0], b[5:0]};

    // byte counting, limit and utf-8 decode
    always_comb
    begin
        upd = cur;
        if (item.has_byte)
        begin
            if (cur.count >= limit)
            begin
                upd.err = utf8v_pkg::ERR_TOO_LONG;
            end
            else
            begin
                upd.count = cur.count + 1'b1;
                if (cur.err == utf8v_pkg::ERR_NONE)
                begin
                    if (cur.expected == 2'd0)
                    begin
                        if (b < 8'h80)
                        begin
                            if (is_forbidden({13'd0, b}))
                                upd.err = utf8v_pkg::ERR_FORBIDDEN;
                        end
                        else if (b inside {[8'hc2:8'hdf]})
                        begin
                            upd.cp       = {16'd0, b[4:0]};
                            upd.expected = 2'd1;
                            upd.cls      = 2'd1;
                        end
                        else if (b inside {[8'he0:8'hef]})
                        begin
                            upd.cp       = {17'd0, b[3:0]};
                            upd.expected = 2'd2;
                            upd.cls      = 2'd2;
                        end
                        else if (b inside {[8'hf0:8'hf4]})
                        begin
                            upd.cp       = {18'd0, b[2:0]};
                            upd.expected = 2'd3;
                            upd.cls      = 2'd3;
                        end
                        else
                        begin
                            upd.err = utf8v_pkg::ERR_BAD_LEAD;
                        end
                    end
                    else if (b[7:6] != 2'b10)
                    begin
                        upd.err = utf8v_pkg::ERR_BAD_CONT;
                    end
                    else
                    begin
                        upd.cp       = cp_shift;
                        upd.expected = cur.expected - 2'd1;
                        if (cur.expected == 2'd1)
                            upd.err = check_cp(cp_shift, cur.cls);
                    end
                end
            end
        end
    end

    // verdict at end of text, open sequence counts as truncated
    always_comb
    begin
        if (upd.err == utf8v_pkg::ERR_NONE && upd.expected != 2'd0)
            fin_err = utf8v_pkg::ERR_TRUNCATED;
        else
            fin_err = upd.err;
        result.text_ok    = (fin_err == utf8v_pkg::ERR_NONE);
        result.error_kind = fin_err;
        nxt = item.text_end ? '0 : upd;
    end

endmodule

@@ rtl/core/utf8v_out_stage.sv @@
// result register toward the output channel
module utf8v_out_stage
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  utf8v_pkg::out_item_t load_data,
    output logic                 ready,
    output logic                 out_valid,
    input  logic                 out_stall,
    output utf8v_pkg::out_item_t out_data
);

    logic                 valid_reg;
    logic                 valid_next;
    utf8v_pkg::out_item_t data_reg;

    // slot is free when empty or being taken this cycle
    assign ready = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (ready)
            valid_next = load;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // payload captured on load
    always_ff @(posedge clk)
    begin
        if (ready && load)
            data_reg <= load_data;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ rtl/core/utf8_display_text_validator_top.sv @@
// top level of the strict utf-8 display text validator
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------
//  in       | in_valid / in_stall    | in_data  (byte_value, has_byte, text_end)
//  out      | out_valid / out_stall  | out_data (text_ok, error_kind)
//  cfg      | cfg_we                 | cfg_data (max_text_bytes)
//
// one byte transaction per cycle while in_stall is low; each passes an input
// register, then the decode logic updates the text state and loads the result
// register, from which the verdict of a closing transaction is presented.
// reset clears the text state and sets the byte limit to 256.
// only closing transactions wait on a full result register; in_stall rises
// while such a transaction sits in the input register and out_stall holds.
`include "utf8_display_text_validator_top_macros.svh"

module utf8_display_text_validator_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [utf8v_pkg::COUNT_W-1:0]       cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  utf8v_pkg::in_item_t                 in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output utf8v_pkg::out_item_t                out_data
);

    logic [utf8v_pkg::COUNT_W-1:0] max_reg;
    logic [utf8v_pkg::COUNT_W-1:0] limit;
    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    utf8v_pkg::in_item_t           s1_data_reg;
    utf8v_pkg::dec_state_t         state_reg;
    utf8v_pkg::dec_state_t         state_next;
    utf8v_pkg::out_item_t          result;
    logic                          out_ready;
    logic                          advance;
    logic                          in_take;
    logic                          s1_end;
    logic                          end_take;
    logic                          out_clean;

    // byte limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_reg <= utf8v_pkg::LIMIT_RESET;
        else if (cfg_we)
            max_reg <= cfg_data;
    end

    assign limit = (max_reg < utf8v_pkg::COUNT_W'(utf8v_pkg::MAX_TEXT_BYTES))
                 ? max_reg : utf8v_pkg::COUNT_W'(utf8v_pkg::MAX_TEXT_BYTES);

    // input stage moves on unless a verdict finds the result slot full
    assign advance  = s1_valid_reg && (!s1_data_reg.text_end || out_ready);
    assign in_stall = s1_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;
    assign s1_end   = s1_valid_reg && s1_data_reg.text_end;
    assign end_take = advance && s1_data_reg.text_end;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (advance || !s1_valid_reg)
            s1_valid_next = in_take;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            s1_data_reg <= in_data;
    end

    // decode logic
    utf8v_decode u_decode
    (
        .cur    (state_reg),
        .item   (s1_data_reg),
        .limit  (limit),
        .nxt    (state_next),
        .result (result)
    );

    // running text state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (advance)
            state_reg <= state_next;
    end

    // result register
    utf8v_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (end_take),
        .load_data (result),
        .ready     (out_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign out_clean = (out_data.error_kind == utf8v_pkg::ERR_NONE);

    // checks
    `UTF8V_ASSERT_NOW(a_stall_needs_item, clk, rst_n, in_stall, s1_end)
    `UTF8V_ASSERT_NEXT(a_end_gives_result, clk, rst_n, end_take, out_valid)
    `UTF8V_ASSERT_NEXT(a_end_clears_state, clk, rst_n, end_take, state_reg == '0)
    `UTF8V_ASSERT_NOW(a_ok_matches_kind, clk, rst_n, out_valid, out_data.text_ok == out_clean)

endmodule

@@ test/utf8_display_text_validator_top_test.sv @@
// testbench for the utf8 display text validator: directed and random texts
`timescale 1ns / 1ps

module utf8_display_text_validator_top_test;

    // one directed transaction, with its verdict typed in where it is obvious
    typedef struct {
        utf8v_pkg::in_item_t  item;
        bit                   typed;
        utf8v_pkg::out_item_t want;
    } plan_row_t;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          cfg_we    = 1'b0;
    logic [utf8v_pkg::COUNT_W-1:0] cfg_data  = '0;
    logic                          in_valid  = 1'b0;
    logic                          in_stall;
    utf8v_pkg::in_item_t           in_data   = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    utf8v_pkg::out_item_t          out_data;

    // predictor copy of the register and the text state
    logic [utf8v_pkg::COUNT_W-1:0] limit_reg  = utf8v_pkg::LIMIT_RESET;
    logic [1:0]                    owed       = '0;
    logic [20:0]                   cp_acc     = '0;
    logic [1:0]                    seq_class  = '0;
    logic [utf8v_pkg::COUNT_W-1:0] byte_total = '0;
    utf8v_pkg::err_kind_t          first_err  = utf8v_pkg::ERR_NONE;

    utf8v_pkg::out_item_t          verdict_q[$];
    bit                            row_typed = 1'b0;
    utf8v_pkg::out_item_t          row_want  = '0;
    bit                            steady    = 1'b0;
    int                            fail_count = 0;
    int                            items_sent = 0;
    plan_row_t                     plan [0:24];

    utf8_display_text_validator_top DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    function automatic plan_row_t mk(logic [7:0] b, bit has, bit fin, bit typed,
                                     bit ok, utf8v_pkg::err_kind_t kind);
        plan_row_t r;
        r.item  = '{byte_value: b, has_byte: has, text_end: fin};
        r.typed = typed;
        r.want  = '{text_ok: ok, error_kind: kind};
        return r;
    endfunction

    // controls, DEL and the banned format characters
    function automatic bit is_banned(logic [20:0] cp);
        return cp < 21'h20 || (cp >= 21'h7f && cp <= 21'h9f) || cp == 21'h061c ||
               (cp >= 21'h200e && cp <= 21'h200f) ||
               (cp >= 21'h2028 && cp <= 21'h202e) ||
               (cp >= 21'h2066 && cp <= 21'h2069);
    endfunction

    // advance the text state by one transaction, give the verdict on text end
    task automatic predict_text_item(input utf8v_pkg::in_item_t it, output bit got,
                                     output utf8v_pkg::out_item_t res);
        logic [7:0]  b;
        logic [20:0] floor_cp;
        b   = it.byte_value;
        got = 1'b0;
        res = '0;
        if (it.has_byte)
        begin
            if (byte_total >= limit_reg)
                first_err = utf8v_pkg::ERR_TOO_LONG;
            else
            begin
                byte_total++;
                if (first_err == utf8v_pkg::ERR_NONE)
                begin
                    if (owed == 0)
                    begin
                        // lead byte or plain ascii
                        if (b < 8'h80)
                        begin
                            if (is_banned({13'd0, b}))
                                first_err = utf8v_pkg::ERR_FORBIDDEN;
                        end
                        else if (b >= 8'hc2 && b <= 8'hdf)
                        begin
                            cp_acc = {16'd0, b[4:0]};
                            owed = 2'd1;
                            seq_class = 2'd1;
                        end
                        else if (b >= 8'he0 && b <= 8'hef)
                        begin
                            cp_acc = {17'd0, b[3:0]};
                            owed = 2'd2;
                            seq_class = 2'd2;
                        end
                        else if (b >= 8'hf0 && b <= 8'hf4)
                        begin
                            cp_acc = {18'd0, b[2:0]};
                            owed = 2'd3;
                            seq_class = 2'd3;
                        end
                        else
                            first_err = utf8v_pkg::ERR_BAD_LEAD;
                    end
                    else if (b[7:6] != 2'b10)
                        first_err = utf8v_pkg::ERR_BAD_CONT;
                    else
                    begin
                        // continuation byte, judge the code point once complete
                        cp_acc = {cp_acc[14:0], b[5:0]};
                        owed--;
                        if (owed == 0)
                        begin
                            floor_cp = seq_class == 2'd1 ? 21'h80 :
                                       (seq_class == 2'd2 ? 21'h800 : 21'h10000);
                            if (cp_acc < floor_cp || cp_acc > 21'h10ffff ||
                                (cp_acc >= 21'hd800 && cp_acc <= 21'hdfff))
                                first_err = utf8v_pkg::ERR_RANGE;
                            else if (is_banned(cp_acc))
                                first_err = utf8v_pkg::ERR_FORBIDDEN;
                        end
                    end
                end
            end
        end
        if (it.text_end)
        begin
            if (first_err == utf8v_pkg::ERR_NONE && owed != 0)
                first_err = utf8v_pkg::ERR_TRUNCATED;
            res.text_ok    = (first_err == utf8v_pkg::ERR_NONE);
            res.error_kind = first_err;
            got = 1'b1;
            owed       = '0;
            cp_acc     = '0;
            seq_class  = '0;
            byte_total = '0;
            first_err  = utf8v_pkg::ERR_NONE;
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    // watch both channels: predict on input transactions, check output ones
    always @(posedge clk)
    begin : watch_channels
        bit                   got;
        utf8v_pkg::out_item_t predicted;
        utf8v_pkg::out_item_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predict_text_item(in_data, got, predicted);
                if (got)
                    verdict_q.push_back(row_typed ? row_want : predicted);
            end
            if (out_valid && !out_stall)
            begin
                if (verdict_q.size() == 0)
                    report_mismatch("verdict with none expected");
                else
                begin
                    want = verdict_q.pop_front();
                    if (out_data.text_ok !== want.text_ok)
                        report_mismatch($sformatf("text_ok got %0b want %0b",
                                                  out_data.text_ok, want.text_ok));
                    if (out_data.error_kind !== want.error_kind)
                        report_mismatch($sformatf("error_kind got %0d want %0d",
                                                  out_data.error_kind, want.error_kind));
                end
            end
        end
    end

    // receiver back-pressure
    always @(negedge clk)
        out_stall <= !steady && ($urandom_range(0, 99) < 33);

    // present one transaction and hold it until taken
    task automatic drive_item(input utf8v_pkg::in_item_t it, input bit typed,
                              input utf8v_pkg::out_item_t want);
        int gap;
        gap = (!steady && $urandom_range(0, 99) < 25) ? $urandom_range(1, 3) : 0;
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data   <= it;
        row_typed <= typed;
        row_want  <= want;
        in_valid  <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (it.has_byte || it.text_end)
            items_sent++;
    endtask

    // write the byte limit once the block has gone quiet
    task automatic set_limit(input logic [utf8v_pkg::COUNT_W-1:0] v);
        @(negedge clk);
        in_valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
        cfg_data <= v;
        cfg_we   <= 1'b1;
        limit_reg = v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // one random text, mostly well-formed characters with some damage
    task automatic send_random_text();
        logic [7:0]  text_bytes[$];
        logic [20:0] cp;
        logic [20:0] specials [0:26];
        int          n_chars;
        int          len;
        int          pick;
        bit          end_on_byte;
        specials = '{21'h061c, 21'h200e, 21'h200f, 21'h2028, 21'h202e, 21'h2066,
                     21'h2069, 21'h061b, 21'h061d, 21'h200d, 21'h2010, 21'h2027,
                     21'h202f, 21'h2065, 21'h206a, 21'hd7ff, 21'he000, 21'h10ffff,
                     21'h9f, 21'ha0, 21'h7f, 21'h1f, 21'h20, 21'h7ff, 21'h800,
                     21'hffff, 21'h10000};
        n_chars = ($urandom_range(0, 99) < 8) ? 0 : $urandom_range(1, 10);
        for (int c = 0; c < n_chars; c++)
        begin
            if ($urandom_range(0, 99) < 12)
                text_bytes.push_back(8'($urandom_range(0, 255)));
            else
            begin
                pick = $urandom_range(0, 9);
                case (pick)
                    0, 1, 2, 3: cp = 21'($urandom_range(32'h20, 32'h7e));
                    4:          cp = 21'($urandom_range(32'h0, 32'hff));
                    5:          cp = 21'($urandom_range(32'h100, 32'h7ff));
                    6:          cp = 21'($urandom_range(32'h800, 32'hffff));
                    7:          cp = 21'($urandom_range(32'h10000, 32'h10ffff));
                    8:          cp = specials[$urandom_range(0, 26)];
                    default:    cp = $urandom_range(0, 1) ?
                                     21'($urandom_range(32'hd800, 32'hdfff)) :
                                     21'($urandom_range(32'h110000, 32'h1fffff));
                endcase
                len = cp < 21'h80 ? 1 : (cp < 21'h800 ? 2 : (cp < 21'h10000 ? 3 : 4));
                if ($urandom_range(0, 99) < 10)
                    len = $urandom_range(1, 4);
                // encode at the chosen length, overlong or clipped as it falls
                case (len)
                    1: text_bytes.push_back({1'b0, cp[6:0]});
                    2:
                    begin
                        text_bytes.push_back({3'b110, cp[10:6]});
                        text_bytes.push_back({2'b10, cp[5:0]});
                    end
                    3:
                    begin
                        text_bytes.push_back({4'b1110, cp[15:12]});
                        text_bytes.push_back({2'b10, cp[11:6]});
                        text_bytes.push_back({2'b10, cp[5:0]});
                    end
                    default:
                    begin
                        text_bytes.push_back({5'b11110, cp[20:18]});
                        text_bytes.push_back({2'b10, cp[17:12]});
                        text_bytes.push_back({2'b10, cp[11:6]});
                        text_bytes.push_back({2'b10, cp[5:0]});
                    end
                endcase
                if (len > 1 && $urandom_range(0, 99) < 6)
                    void'(text_bytes.pop_back());
            end
        end
        end_on_byte = text_bytes.size() > 0 && $urandom_range(0, 1);
        foreach (text_bytes[i])
        begin
            // occasional transaction with neither byte nor end
            if ($urandom_range(0, 99) < 4)
                drive_item('{byte_value: 8'($urandom_range(0, 255)), has_byte: 1'b0,
                             text_end: 1'b0}, 1'b0, '0);
            drive_item('{byte_value: text_bytes[i], has_byte: 1'b1,
                         text_end: end_on_byte && i == text_bytes.size() - 1}, 1'b0, '0);
        end
        if (!end_on_byte)
            drive_item('{byte_value: 8'($urandom_range(0, 255)), has_byte: 1'b0,
                         text_end: 1'b1}, 1'b0, '0);
    endtask

    // run limit
    initial
    begin
        #5_000_000;
        $display("FAIL utf8_display_text_validator_top");
        $finish;
    end

    initial
    begin
        int phase_start;
        plan = '{
            mk(8'h00, 0, 1, 1, 1, utf8v_pkg::ERR_NONE),
            mk(8'h41, 0, 0, 0, 0, utf8v_pkg::ERR_NONE),
            mk(8'h41, 1, 1, 1, 1, utf8v_pkg::ERR_NONE),
            mk(8'h00, 1, 1, 1, 0, utf8v_pkg::ERR_FORBIDDEN),
            mk(8'h7f, 1, 1, 1, 0, utf8v_pkg::ERR_FORBIDDEN),
            mk(8'hff, 1, 1, 1, 0, utf8v_pkg::ERR_BAD_LEAD),
            mk(8'h80, 1, 1, 1, 0, utf8v_pkg::ERR_BAD_LEAD),
            mk(8'hc2, 1, 1, 1, 0, utf8v_pkg::ERR_TRUNCATED),
            mk(8'hc2, 1, 0, 0, 0, utf8v_pkg::ERR_NONE),
            mk(8'h41, 1, 1, 1, 0, utf8v_pkg::ERR_BAD_CONT),
            mk(8'hc2, 1, 0, 0, 0, utf8v_pkg::ERR_NONE),
            mk(8'ha0, 1, 1, 0, 0, utf8v_pkg::ERR_NONE),
            mk(8'he0, 1, 0, 0, 0, utf8v_pkg::ERR_NONE),
            mk(8'h80, 1, 0, 0, 0, utf8v_pkg::ERR_NONE),
            mk(8'h80, 1, 1, 1, 0, utf8v_pkg::ERR_RANGE),
            mk(8'hed, 1, 0, 0, 0, utf8v_pkg::ERR_NONE),
            mk(8'ha0, 1, 0, 0, 0, utf8v_pkg::ERR_NONE),
            mk(8'h80, 1, 1, 1, 0, utf8v_pkg::ERR_RANGE),
            mk(8'hf4, 1, 0, 0, 0, utf8v_pkg::ERR_NONE),
            mk(8'h90, 1, 0, 0, 0, utf8v_pkg::ERR_NONE),
            mk(8'h80, 1, 0, 0, 0, utf8v_pkg::ERR_NONE),
            mk(8'h80, 1, 1, 1, 0, utf8v_pkg::ERR_RANGE),
            mk(8'he2, 1, 0, 0, 0, utf8v_pkg::ERR_NONE),
            mk(8'h80, 1, 0, 0, 0, utf8v_pkg::ERR_NONE),
            mk(8'hae, 1, 1, 0, 0, utf8v_pkg::ERR_NONE)
        };

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // directed texts at the reset limit
        foreach (plan[i])
            drive_item(plan[i].item, plan[i].typed, plan[i].want);

        // limit extremes
        set_limit(12'd0);
        repeat (3) send_random_text();
        set_limit(12'd1);
        drive_item('{byte_value: 8'h41, has_byte: 1'b1, text_end: 1'b0}, 1'b0, '0);
        drive_item('{byte_value: 8'h42, has_byte: 1'b1, text_end: 1'b1}, 1'b1,
                   '{text_ok: 1'b0, error_kind: utf8v_pkg::ERR_TOO_LONG});
        repeat (6) send_random_text();
        set_limit(12'hfff);
        for (int i = 0; i < 300; i++)
            drive_item('{byte_value: 8'($urandom_range(8'h20, 8'h7e)), has_byte: 1'b1,
                         text_end: i == 299}, i == 299,
                       '{text_ok: 1'b1, error_kind: utf8v_pkg::ERR_NONE});

        // random phases, each under its own limit
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0:       set_limit(utf8v_pkg::LIMIT_RESET);
                1:       set_limit(12'($urandom_range(2, 24)));
                2:       set_limit(12'hfff);
                3:       set_limit(12'($urandom_range(8, 60)));
                4:       set_limit(12'($urandom_range(0, 4095)));
                default: set_limit(12'($urandom_range(1, 12)));
            endcase
            steady = (p == 2);
            phase_start = items_sent;
            while (items_sent - phase_start < 210)
                send_random_text();
        end
        steady = 1'b0;

        // drain and settle
        @(negedge clk);
        in_valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("PASS utf8_display_text_validator_top");
        else
            $display("FAIL utf8_display_text_validator_top");
        $finish;
    end

endmodule
